// ----- src/cois_pkg.sv -----
// Package for the completion order insertion sorter.
// Holds the record type, the controller/datapath command and status types
// and the default capacity. Depends on nothing.
`default_nettype none

package cois_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned ID_W = 32;
  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic                    done;
    logic signed [KEY_W-1:0] key;
  } rec_t;

  // Commands from the controller to the slot chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

  // Status from the slot chain back to the controller.
  typedef struct packed {
    logic full;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ----- src/cois_slots.sv -----
// Slot chain datapath of the completion order insertion sorter.
// Keeps the records sorted in a row of slots; uses cois_pkg.
`default_nettype none

module cois_slots #(
  parameter int unsigned CAPACITY = cois_pkg::CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cois_pkg::cmd_t        cmd_i,
  input  cois_pkg::rec_t        in_rec_i,
  output cois_pkg::rec_t        head_rec_o,
  output cois_pkg::status_t     status_o
);

  cois_pkg::rec_t        slot_q [CAPACITY];
  cois_pkg::rec_t        slot_d [CAPACITY];
  logic [CAPACITY-1:0]   occ_q;
  logic [CAPACITY-1:0]   occ_d;
  logic [CAPACITY-1:0]   behind;

  // True when the held record has to sit behind the new one: completed
  // records go last, and a strictly larger key goes later, so equal keys
  // keep their arrival order.
  function automatic logic must_follow(cois_pkg::rec_t held, cois_pkg::rec_t fresh);
    logic res;
    if (held.done != fresh.done) begin
      res = held.done;
    end else begin
      res = (held.key > fresh.key);
    end
    return res;
  endfunction

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic prev_behind;
    logic prev_occ;
    logic next_occ;
    cois_pkg::rec_t next_rec;

    assign behind[i] = occ_q[i] & must_follow(slot_q[i], in_rec_i);

    if (i == 0) begin : g_head
      assign prev_behind = 1'b0;
      assign prev_occ    = 1'b1;
    end else begin : g_body
      assign prev_behind = behind[i-1];
      assign prev_occ    = occ_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_occ = 1'b0;
      assign next_rec = slot_q[i];
    end else begin : g_inner
      assign next_occ = occ_q[i+1];
      assign next_rec = slot_q[i+1];
    end

    always_comb begin
      slot_d[i] = slot_q[i];
      occ_d[i]  = occ_q[i];
      if (cmd_i.insert) begin
        occ_d[i] = occ_q[i] | prev_occ;
        if (prev_behind) begin
          if (i == 0) begin
            slot_d[i] = slot_q[i];
          end else begin
            slot_d[i] = slot_q[(i == 0) ? 0 : i-1];
          end
        end else if (prev_occ && (behind[i] || !occ_q[i])) begin
          slot_d[i] = in_rec_i;
        end
      end else if (cmd_i.shift) begin
        occ_d[i]  = next_occ;
        slot_d[i] = next_rec;
      end
    end

    always_ff @(posedge clk_i) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign head_rec_o    = slot_q[0];
  assign status_o.full = occ_q[CAPACITY-1];
  assign status_o.last = occ_q[0] & ~occ_q[1];

  // The occupied slots always form one block starting at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_q >> 1) & ~occ_q) == '0)
    else $error("occupied slots are not contiguous from the head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.insert && cmd_i.shift))
    else $error("insert and shift requested together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !occ_q[CAPACITY-1])
    else $error("insert into a full slot chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> $countones(occ_q) == $countones($past(occ_q)) + 1)
    else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

// ----- src/cois_ctrl.sv -----
// Controller of the completion order insertion sorter.
// Sequences collection and output of a list; uses cois_pkg.
`default_nettype none

module cois_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           final_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                end_of_list_o,
  output logic                dropped_o,
  output cois_pkg::cmd_t      cmd_o,
  input  cois_pkg::status_t   status_i
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic state_q, state_d;
  logic overflow_q, overflow_d;
  logic in_acc;
  logic out_acc;

  assign in_stall_o  = (state_q == ST_EMIT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;

  assign cmd_o.insert = in_acc & ~status_i.full;
  assign cmd_o.shift  = out_acc;

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (status_i.full) begin
            overflow_d = 1'b1;
          end
          if (final_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc && status_i.last) begin
          state_d    = ST_COLLECT;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_COLLECT;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  assign end_of_list_o = status_i.last;
  assign dropped_o     = overflow_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && final_i) |=> out_valid_o)
    else $error("final word did not start the output of the list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |-> $stable(overflow_q))
    else $error("drop flag changed while the list was being emitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && status_i.last) |=> !out_valid_o && !overflow_q)
    else $error("controller did not return to collection after the list");

endmodule

`default_nettype wire

// ----- src/completion_order_insertion_sorter.sv -----
// Top level of the completion order insertion sorter.
// Joins the controller cois_ctrl and the slot chain cois_slots; uses cois_pkg.
//
// Records are taken one word per cycle while in_stall_o is low and inserted
// at once into a chain of CAPACITY slots, where every slot compares itself
// with the new record in parallel and the later ones move up by one.
// Incomplete tasks sort first, then ascending signed key, equal keys in
// arrival order. The word marked as final makes the block emit the whole
// list from the head of the chain, one word per cycle while out_stall_i is
// low, with end_of_list_o on the last one; no input is taken meanwhile.
// Records arriving while the chain is full are discarded and every word of
// that list then carries dropped_records_o.
`default_nettype none

module completion_order_insertion_sorter #(
  parameter int unsigned CAPACITY = cois_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [cois_pkg::ID_W-1:0]          task_id_i,
  input  wire logic                               done_flag_i,
  input  wire logic signed [cois_pkg::KEY_W-1:0]  order_key_i,
  input  wire logic                               final_record_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [cois_pkg::ID_W-1:0]               out_task_id_o,
  output logic                                    out_done_flag_o,
  output logic signed [cois_pkg::KEY_W-1:0]       out_order_key_o,
  output logic                                    end_of_list_o,
  output logic                                    dropped_records_o
);

  cois_pkg::cmd_t    cmd;
  cois_pkg::status_t status;
  cois_pkg::rec_t    in_rec;
  cois_pkg::rec_t    head_rec;

  assign in_rec.id   = task_id_i;
  assign in_rec.done = done_flag_i;
  assign in_rec.key  = order_key_i;

  cois_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .final_i       (final_record_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .end_of_list_o (end_of_list_o),
    .dropped_o     (dropped_records_o),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  cois_slots #(
    .CAPACITY (CAPACITY)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_rec_i   (in_rec),
    .head_rec_o (head_rec),
    .status_o   (status)
  );

  assign out_task_id_o   = head_rec.id;
  assign out_done_flag_o = head_rec.done;
  assign out_order_key_o = head_rec.key;

endmodule

`default_nettype wire
